// ===== src/uist_pkg.sv =====
// ----------------------------------------------------------------------------
// uist_pkg
// Shared sizes, codes and result type for the unique id set table.
// ----------------------------------------------------------------------------
package uist_pkg;

    // table capacity, entries
    localparam int CAPACITY = 256;

    // fixed port widths
    localparam int ID_W    = 32;
    localparam int POS_W   = 8;
    localparam int SLOT_W  = 8;
    localparam int COUNT_W = 9;

    // internal widths follow the capacity
    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [CMP_W-1:0]  t_cmp;
    typedef logic [ID_W-1:0]   t_id;

    typedef enum logic [1:0] {
        ACT_ADD   = 2'd0,
        ACT_CHECK = 2'd1,
        ACT_GET   = 2'd2,
        ACT_CLEAR = 2'd3
    } t_action;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        t_id               value;
        logic              full;
    } t_result;

endpackage

// ===== src/uist_ram.sv =====
// ----------------------------------------------------------------------------
// uist_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module uist_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 256,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/unique_id_set_table.sv =====
// ----------------------------------------------------------------------------
// unique_id_set_table
// Insertion-ordered set of 32-bit ids with add, check, get and clear.
// ----------------------------------------------------------------------------
// Flow: add/check scan the stored ids from slot 0 and stop at the first match;
//   a miss scans every stored entry (an empty table skips the scan); get reads
//   the RAM only when the position is below the count; clear skips the RAM.
// Throughput: one beat in flight; the scan reads one entry per cycle from the
//   id RAM's single read port.
// Reset: count, min and max clear at once; the id RAM is not cleared, only
//   entries below the count are ever read.
// ----------------------------------------------------------------------------
module unique_id_set_table
    import uist_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_action,
    input  logic [ID_W-1:0]    i_chunk_id,
    input  logic [POS_W-1:0]   i_position,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_hit,
    output logic [SLOT_W-1:0]  o_slot,
    output logic [ID_W-1:0]    o_value,
    output logic [COUNT_W-1:0] o_count,
    output logic [ID_W-1:0]    o_earliest,
    output logic [ID_W-1:0]    o_latest,
    output logic               o_full_res
);

    // IDLE  : take a request beat
    // SCAN  : compare one RAM word per cycle against the request id
    // MISS  : id not present; append it (add) or flag full
    // GET   : capture the word read at the requested position
    // DONE  : park the result until the output register is free
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MISS,
        S_GET,
        S_DONE
    } t_state;

    t_state  r_state, n_state;
    t_action r_act, n_act;
    t_id     r_id, n_id;
    t_addr   r_idx, n_idx;       // index of the word now on the RAM output
    t_cnt    r_count, n_count;
    t_id     r_min, n_min;
    t_id     r_max, n_max;
    t_result r_res, n_res;

    // output register
    logic               r_out_valid, n_out_valid;
    t_result            r_out, n_out;
    logic [COUNT_W-1:0] r_out_count, n_out_count;
    t_id                r_out_min, n_out_min;
    t_id                r_out_max, n_out_max;

    // RAM port signals
    logic  rd_en;
    t_addr rd_addr;
    t_id   rd_data;
    logic  wr_en;
    t_addr wr_addr;

    logic  accept;
    t_cmp  pos_ext;
    t_cmp  count_ext;
    logic  out_free;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign pos_ext    = t_cmp'(i_position);
    assign count_ext  = t_cmp'(r_count);
    assign out_free   = !r_out_valid || !i_out_stall;
    // appends always land at the current fill level
    assign wr_addr    = r_count[ADDR_W-1:0];

    uist_ram #(
        .WIDTH (ID_W),
        .DEPTH (CAPACITY)
    ) u_id_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (r_id),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state     = r_state;
        n_act       = r_act;
        n_id        = r_id;
        n_idx       = r_idx;
        n_count     = r_count;
        n_min       = r_min;
        n_max       = r_max;
        n_res       = r_res;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        n_out_count = r_out_count;
        n_out_min   = r_out_min;
        n_out_max   = r_out_max;
        rd_en       = 1'b0;
        rd_addr     = r_idx + t_addr'(1);
        wr_en       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_act = t_action'(i_action);
                    n_id  = i_chunk_id;
                    n_res = '0;
                    unique case (t_action'(i_action)) inside
                        ACT_ADD, ACT_CHECK: begin
                            if (r_count == '0) begin
                                n_state = S_MISS;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = '0;
                                n_idx   = '0;
                                n_state = S_SCAN;
                            end
                        end
                        ACT_GET: begin
                            if (pos_ext < count_ext) begin
                                rd_en       = 1'b1;
                                rd_addr     = pos_ext[ADDR_W-1:0];
                                n_res.hit   = 1'b1;
                                n_res.slot  = SLOT_W'(i_position);
                                n_state     = S_GET;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                        ACT_CLEAR: begin
                            n_count = '0;
                            n_min   = '0;
                            n_max   = '0;
                            n_state = S_DONE;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (rd_data == r_id) begin
                    n_res.hit  = 1'b1;
                    n_res.slot = SLOT_W'(r_idx);
                    n_state    = S_DONE;
                end else if ((t_cnt'(r_idx) + t_cnt'(1)) == r_count) begin
                    n_state = S_MISS;
                end else begin
                    // fetch the next word; rd_addr default is r_idx + 1
                    rd_en = 1'b1;
                    n_idx = r_idx + t_addr'(1);
                end
            end
            S_MISS: begin
                if (r_act == ACT_ADD) begin
                    if (r_count < t_cnt'(CAPACITY)) begin
                        wr_en      = 1'b1;
                        n_res.slot = SLOT_W'(r_count);
                        n_count    = r_count + t_cnt'(1);
                        if (r_count == '0) begin
                            n_min = r_id;
                            n_max = r_id;
                        end else begin
                            if (r_id < r_min) n_min = r_id;
                            if (r_id > r_max) n_max = r_id;
                        end
                    end else begin
                        n_res.full = 1'b1;
                    end
                end
                n_state = S_DONE;
            end
            S_GET: begin
                n_res.value = rd_data;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_out_count = COUNT_W'(r_count);
                    n_out_min   = r_min;
                    n_out_max   = r_max;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_min       <= '0;
            r_max       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_min       <= n_min;
            r_max       <= n_max;
            r_out_valid <= n_out_valid;
        end
        r_act       <= n_act;
        r_id        <= n_id;
        r_idx       <= n_idx;
        r_res       <= n_res;
        r_out       <= n_out;
        r_out_count <= n_out_count;
        r_out_min   <= n_out_min;
        r_out_max   <= n_out_max;
    end

    assign o_out_valid = r_out_valid;
    assign o_hit       = r_out.hit;
    assign o_slot      = r_out.slot;
    assign o_value     = r_out.value;
    assign o_full_res  = r_out.full;
    assign o_count     = r_out_count;
    assign o_earliest  = r_out_min;
    assign o_latest    = r_out_max;

endmodule

// ===== tb/sv/tb_unique_id_set_table.sv =====
// ----------------------------------------------------------------------------
// tb_unique_id_set_table
// Self-checking bench for the unique id set table. A behavioral copy of the
// table predicts every result at the moment a request beat is accepted; the
// result monitor compares each returned beat field by field, in order.
// Stimulus runs from directed corner cases through full-table fills to a
// long random mix, with random idle and stall bursts on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_unique_id_set_table;
    import uist_pkg::*;

    // cycles with no accepted beat on either side before the run is abandoned;
    // the slowest item is a full scan plus chained stalls
    localparam int QUIET_LIMIT = 4000;

    // one predicted result beat
    typedef struct packed {
        logic               hit;
        logic [SLOT_W-1:0]  slot;
        t_id                value;
        logic [COUNT_W-1:0] count;
        t_id                earliest;
        t_id                latest;
        logic               full;
    } t_table_reply;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [1:0]         i_action;
    logic [ID_W-1:0]    i_chunk_id;
    logic [POS_W-1:0]   i_position;
    logic               o_out_valid;
    logic               i_out_stall;
    logic               o_hit;
    logic [SLOT_W-1:0]  o_slot;
    logic [ID_W-1:0]    o_value;
    logic [COUNT_W-1:0] o_count;
    logic [ID_W-1:0]    o_earliest;
    logic [ID_W-1:0]    o_latest;
    logic               o_full_res;

    unique_id_set_table dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_action    (i_action),
        .i_chunk_id  (i_chunk_id),
        .i_position  (i_position),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_hit       (o_hit),
        .o_slot      (o_slot),
        .o_value     (o_value),
        .o_count     (o_count),
        .o_earliest  (o_earliest),
        .o_latest    (o_latest),
        .o_full_res  (o_full_res)
    );

    // ------------------------------------------------------------------------
    // Behavioral copy of the table
    // ------------------------------------------------------------------------
    t_id         id_mem [CAPACITY];
    int unsigned stored_n = 0;
    t_id         low_id   = '0;
    t_id         high_id  = '0;

    // expected result beats, oldest first
    t_table_reply replies_due [$];

    int  mismatches = 0;
    // random idle/stall bursts enabled
    bit  idle_on    = 1'b1;

    // Apply one request to the copy and return the result it must produce.
    function automatic t_table_reply table_apply(t_action act, t_id id,
                                                 logic [POS_W-1:0] pos);
        t_table_reply r;
        bit           found;
        int unsigned  at;
        r     = '0;
        found = 1'b0;
        at    = 0;
        // linear search, first match wins (ids are unique anyway)
        if (act == ACT_ADD || act == ACT_CHECK) begin
            for (int unsigned k = 0; k < stored_n && !found; k++) begin
                if (id_mem[k] == id) begin
                    found = 1'b1;
                    at    = k;
                end
            end
        end
        case (act)
            ACT_ADD: begin
                if (found) begin
                    r.hit  = 1'b1;
                    r.slot = at[SLOT_W-1:0];
                end else if (stored_n < CAPACITY) begin
                    id_mem[stored_n] = id;
                    // first entry seeds both bounds
                    if (stored_n == 0) begin
                        low_id  = id;
                        high_id = id;
                    end else begin
                        if (id < low_id)  low_id  = id;
                        if (id > high_id) high_id = id;
                    end
                    r.slot   = stored_n[SLOT_W-1:0];
                    stored_n = stored_n + 1;
                end else begin
                    // table full: refused, nothing changes
                    r.full = 1'b1;
                end
            end
            ACT_CHECK: begin
                if (found) begin
                    r.hit  = 1'b1;
                    r.slot = at[SLOT_W-1:0];
                end
            end
            ACT_GET: begin
                // only positions below the count are readable
                if (pos < stored_n) begin
                    r.hit   = 1'b1;
                    r.slot  = pos;
                    r.value = id_mem[pos];
                end
            end
            default: begin
                stored_n = 0;
                low_id   = '0;
                high_id  = '0;
            end
        endcase
        r.count    = stored_n[COUNT_W-1:0];
        r.earliest = low_id;
        r.latest   = high_id;
        return r;
    endfunction

    function automatic void check_field(string name, logic [ID_W-1:0] want,
                                        logic [ID_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Clock, reset and initial drive
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_action    <= ACT_CHECK;
        i_chunk_id  <= '0;
        i_position  <= '0;
        i_out_stall <= 1'b0;
    end

    // ------------------------------------------------------------------------
    // Monitors. Sampling right after the edge sees the values the block saw,
    // since every input here and every register in the block moves by NBA.
    // ------------------------------------------------------------------------

    // request side: predict on every accepted beat
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall)
            replies_due.push_back(table_apply(t_action'(i_action), i_chunk_id,
                                              i_position));
    end

    // result side: compare against the oldest prediction
    always @(posedge i_clk) begin
        t_table_reply want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (replies_due.size() == 0) begin
                $display({"%0t: unexpected result beat, expected none, ",
                          "actual hit=%b slot=%h value=%h count=%h"},
                         $time, o_hit, o_slot, o_value, o_count);
                mismatches++;
            end else begin
                want = replies_due.pop_front();
                check_field("hit",      ID_W'(want.hit),   ID_W'(o_hit));
                check_field("slot",     ID_W'(want.slot),  ID_W'(o_slot));
                check_field("value",    want.value,        o_value);
                check_field("count",    ID_W'(want.count), ID_W'(o_count));
                check_field("earliest", want.earliest,     o_earliest);
                check_field("latest",   want.latest,       o_latest);
                check_field("full_res", ID_W'(want.full),  ID_W'(o_full_res));
            end
        end
    end

    // result back-pressure: random stall bursts
    int unsigned stall_left = 0;
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left  = stall_left - 1;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            i_out_stall <= 1'b1;
            stall_left  = $urandom_range(1, 6) - 1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // watchdog: too long with no beat moving on either channel
    int unsigned quiet_cycles = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------------

    // Present one request beat and return at the edge that accepts it. Valid
    // stays high into the next beat unless a random gap is inserted first.
    task automatic send_beat(input t_action act, input t_id id,
                             input logic [POS_W-1:0] pos);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_chunk_id <= id;
        i_position <= pos;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // 256 distinct adds: an odd step keeps base + k*step unique mod 2^32
    task automatic fill_table(input t_id base, input t_id step);
        for (int k = 0; k < CAPACITY; k++)
            send_beat(ACT_ADD, base + t_id'(k) * step, POS_W'($urandom_range(0, 255)));
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // every operation against an empty table
    task automatic test_empty_table();
        send_beat(ACT_CHECK, 32'h0000_0000, 8'd0);
        send_beat(ACT_GET,   32'hFFFF_FFFF, 8'd0);
        send_beat(ACT_GET,   32'h0000_0000, 8'd255);
        send_beat(ACT_CLEAR, 32'hFFFF_FFFF, 8'd255);
        send_beat(ACT_ADD,   32'hFFFF_FFFF, 8'd0);
        send_beat(ACT_CLEAR, 32'h0000_0000, 8'd0);
    endtask

    // id extremes, duplicate add, hit/miss check, get inside and past count
    task automatic test_basic_ops();
        send_beat(ACT_ADD,   32'h0000_0000, 8'd0);
        send_beat(ACT_ADD,   32'hFFFF_FFFF, 8'd0);
        send_beat(ACT_ADD,   32'h0000_0000, 8'd0);   // duplicate -> hit slot 0
        send_beat(ACT_ADD,   32'h8000_0000, 8'd0);
        send_beat(ACT_ADD,   32'h7FFF_FFFF, 8'd0);
        send_beat(ACT_CHECK, 32'hFFFF_FFFF, 8'd0);
        send_beat(ACT_CHECK, 32'h1234_5678, 8'd0);   // absent
        send_beat(ACT_GET,   32'h0000_0000, 8'd0);
        send_beat(ACT_GET,   32'h0000_0000, 8'd3);   // last valid entry
        send_beat(ACT_GET,   32'h0000_0000, 8'd4);   // equal to count
        send_beat(ACT_GET,   32'h0000_0000, 8'd255);
        send_beat(ACT_CLEAR, 32'h0000_0000, 8'd0);
        send_beat(ACT_GET,   32'h0000_0000, 8'd0);   // stale entry after clear
    endtask

    // fill to capacity, then refused add, hits at both ends, full-range gets
    task automatic test_full_table();
        t_id base;
        t_id step;
        base = $urandom();
        step = $urandom() | 32'd1;
        send_beat(ACT_CLEAR, $urandom(), POS_W'($urandom_range(0, 255)));
        fill_table(base, step);
        send_beat(ACT_ADD,   base + 32'd256 * step, 8'd0);  // refused
        send_beat(ACT_ADD,   base + 32'd255 * step, 8'd0);  // hit, last slot
        send_beat(ACT_ADD,   base, 8'd0);                    // hit, slot 0
        send_beat(ACT_CHECK, base + 32'd255 * step, 8'd0);
        send_beat(ACT_CHECK, base + 32'd300 * step, 8'd0);  // absent, full scan
        send_beat(ACT_GET,   32'h0, 8'd255);
        send_beat(ACT_GET,   32'h0, 8'd0);
        send_beat(ACT_CLEAR, 32'h0, 8'd0);
    endtask

    // Random mix over a small id pool so duplicates and hits are common.
    task automatic run_random_mix(input int n_items);
        t_id pool [40];
        int  r;
        t_id id;
        logic [POS_W-1:0] pos;
        pool[0] = 32'h0000_0000;
        pool[1] = 32'hFFFF_FFFF;
        for (int k = 2; k < 40; k++) pool[k] = $urandom();
        for (int n = 0; n < n_items; n++) begin
            r   = $urandom_range(0, 99);
            id  = ($urandom_range(0, 9) < 7) ? pool[$urandom_range(0, 39)] : $urandom();
            // gets mostly land inside the stored range
            if (stored_n > 0 && $urandom_range(0, 9) < 6)
                pos = POS_W'($urandom_range(0, stored_n - 1));
            else
                pos = POS_W'($urandom_range(0, 255));
            if (r < 45)      send_beat(ACT_ADD,   id, pos);
            else if (r < 70) send_beat(ACT_CHECK, id, pos);
            else if (r < 97) send_beat(ACT_GET,   id, pos);
            else             send_beat(ACT_CLEAR, id, pos);
        end
    endtask

    task automatic test_random_mix();
        run_random_mix(350);
    endtask

    // full table under random traffic: refusals, hits anywhere, full scans
    task automatic test_full_churn();
        t_id base;
        t_id step;
        int  r;
        base = $urandom();
        step = $urandom() | 32'd1;
        send_beat(ACT_CLEAR, $urandom(), POS_W'($urandom_range(0, 255)));
        fill_table(base, step);
        for (int n = 0; n < 60; n++) begin
            r = $urandom_range(0, 3);
            case (r)
                0: send_beat(ACT_ADD, base + t_id'($urandom_range(256, 4000)) * step,
                             POS_W'($urandom_range(0, 255)));
                1: send_beat(ACT_ADD, base + t_id'($urandom_range(0, 255)) * step,
                             POS_W'($urandom_range(0, 255)));
                2: send_beat(ACT_CHECK, ($urandom_range(0, 1) == 0) ? $urandom()
                             : base + t_id'($urandom_range(0, 255)) * step,
                             POS_W'($urandom_range(0, 255)));
                default: send_beat(ACT_GET, $urandom(), POS_W'($urandom_range(0, 255)));
            endcase
        end
        send_beat(ACT_CLEAR, $urandom(), POS_W'($urandom_range(0, 255)));
    endtask

    // back-to-back beats, receiver always ready
    task automatic test_steady_stream();
        idle_on = 1'b0;
        run_random_mix(120);
    endtask

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        test_basic_ops();
        test_full_table();
        test_random_mix();
        test_full_churn();
        test_steady_stream();

        i_in_valid <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
        // drain window: catches any stray extra result beat
        repeat (CAPACITY + 8) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/uist_pkg.sv
src/uist_ram.sv
src/unique_id_set_table.sv
tb/sv/tb_unique_id_set_table.sv
